>>> hw/rtl/wfm_pkg.sv
// ----------------------------------------------------------------------------
// wfm_pkg
// shared types, constants and helpers of the websocket frame masker
// ----------------------------------------------------------------------------
package wfm_pkg;

  // default depth of the command queue between front and back
  localparam int unsigned QueueDepth = 4;

  // header bits and the extended-length marker
  localparam logic [7:0] HdrFinBit   = 8'h80;
  localparam logic [7:0] HdrMaskBit  = 8'h80;
  localparam logic [6:0] LenExt16    = 7'd126;
  localparam logic [15:0] LenExtMin  = 16'd126;

  // input item kinds
  localparam logic FuncStart   = 1'b0;
  localparam logic FuncPayload = 1'b1;

  // header step counter: last step of a short and of an extended header
  localparam logic [2:0] StepLastShort = 3'd5;
  localparam logic [2:0] StepLastLong  = 3'd7;
  localparam logic [2:0] MaskBaseShort = 3'd2;
  localparam logic [2:0] MaskBaseLong  = 3'd4;

  typedef enum logic {
    CMD_BYTE,
    CMD_HEADER
  } wfm_cmd_kind_e;

  // one queued command: a ready-made result byte or a header to expand
  typedef struct packed {
    wfm_cmd_kind_e kind;
    logic [7:0]    out_byte;
    logic          last;
    logic          error;
    logic [3:0]    opcode;
    logic [15:0]   frame_length;
    logic [31:0]   mask_key;
  } wfm_cmd_t;

  // mask key byte for a payload position, first byte in bits 31:24
  function automatic logic [7:0] mask_byte(input logic [31:0] key, input logic [1:0] phase);
    logic [7:0] b;
    case (phase)
      2'd0:    b = key[31:24];
      2'd1:    b = key[23:16];
      2'd2:    b = key[15:8];
      default: b = key[7:0];
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/wfm_if.sv
// ----------------------------------------------------------------------------
// wfm channel interfaces
// valid/ready channels for input items and frame bytes
// ----------------------------------------------------------------------------
interface wfm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [3:0]  opcode;
  logic [15:0] frame_length;
  logic [31:0] mask_key;
  logic [7:0]  data_byte;

  modport source (output valid, func, opcode, frame_length, mask_key, data_byte,
                  input ready);
  modport sink   (input valid, func, opcode, frame_length, mask_key, data_byte,
                  output ready);
endinterface

interface wfm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink   (input valid, out_byte, last, error, output ready);
endinterface

>>> hw/rtl/wfm_front.sv
// ----------------------------------------------------------------------------
// wfm_front
// accepts input items, tracks the open frame and masks payload bytes
// ----------------------------------------------------------------------------
module wfm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  wfm_in_if.sink          in_i,
  input  logic            q_full_i,
  output logic            push_o,
  output wfm_pkg::wfm_cmd_t cmd_o
);

  logic        open_q, open_d;
  logic [15:0] left_q, left_d;
  logic [31:0] mask_q, mask_d;
  logic [1:0]  phase_q, phase_d;
  logic        accept;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && !q_full_i;
  assign push_o     = accept;

  always_comb begin
    open_d  = open_q;
    left_d  = left_q;
    mask_d  = mask_q;
    phase_d = phase_q;

    cmd_o.kind         = wfm_pkg::CMD_BYTE;
    cmd_o.out_byte     = 8'h00;
    cmd_o.last         = 1'b0;
    cmd_o.error        = 1'b0;
    cmd_o.opcode       = in_i.opcode;
    cmd_o.frame_length = in_i.frame_length;
    cmd_o.mask_key     = in_i.mask_key;

    if (in_i.func == wfm_pkg::FuncStart) begin
      cmd_o.kind = wfm_pkg::CMD_HEADER;
      if (accept) begin
        mask_d  = in_i.mask_key;
        left_d  = in_i.frame_length;
        phase_d = 2'd0;
        open_d  = (in_i.frame_length != 16'd0);
      end
    end else if (!open_q) begin
      // payload with no open frame
      cmd_o.error = 1'b1;
    end else begin
      cmd_o.out_byte = in_i.data_byte ^ wfm_pkg::mask_byte(mask_q, phase_q);
      cmd_o.last     = (left_q == 16'd1);
      if (accept) begin
        left_d  = left_q - 16'd1;
        phase_d = phase_q + 2'd1;
        open_d  = (left_q != 16'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= 1'b0;
      left_q  <= 16'd0;
      mask_q  <= 32'd0;
      phase_q <= 2'd0;
    end else begin
      open_q  <= open_d;
      left_q  <= left_d;
      mask_q  <= mask_d;
      phase_q <= phase_d;
    end
  end

endmodule

>>> hw/rtl/wfm_queue.sv
// ----------------------------------------------------------------------------
// wfm_queue
// small command fifo between front and back
// ----------------------------------------------------------------------------
module wfm_queue #(
  parameter int unsigned Depth = wfm_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wfm_pkg::wfm_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output wfm_pkg::wfm_cmd_t head_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  wfm_pkg::wfm_cmd_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == LastIdx) ? '0 : wptr_q + PtrW'(1);
    if (do_pop)  rptr_d = (rptr_q == LastIdx) ? '0 : rptr_q + PtrW'(1);
    if (do_push && !do_pop)      cnt_d = cnt_q + CntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/wfm_back.sv
// ----------------------------------------------------------------------------
// wfm_back
// expands queued commands into frame bytes behind an output register
// ----------------------------------------------------------------------------
module wfm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wfm_pkg::wfm_cmd_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  wfm_out_if.source         out_o
);

  logic [2:0] step_q, step_d;
  logic       out_valid_q;
  logic [7:0] out_byte_q, byte_d;
  logic       out_last_q, last_d;
  logic       out_error_q;
  logic       load;
  logic       is_hdr, is_long;
  logic [2:0] last_step, mask_base, mask_idx;

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last     = out_last_q;
  assign out_o.error    = out_error_q;

  assign load      = !empty_i && (!out_valid_q || out_o.ready);
  assign is_hdr    = (head_i.kind == wfm_pkg::CMD_HEADER);
  assign is_long   = (head_i.frame_length >= wfm_pkg::LenExtMin);
  assign last_step = is_long ? wfm_pkg::StepLastLong : wfm_pkg::StepLastShort;
  assign mask_base = is_long ? wfm_pkg::MaskBaseLong : wfm_pkg::MaskBaseShort;
  assign mask_idx  = step_q - mask_base;

  always_comb begin
    byte_d = head_i.out_byte;
    last_d = head_i.last;
    if (is_hdr) begin
      last_d = 1'b0;
      if (step_q == 3'd0) begin
        byte_d = wfm_pkg::HdrFinBit | {4'd0, head_i.opcode};
      end else if (step_q == 3'd1) begin
        byte_d = wfm_pkg::HdrMaskBit |
                 {1'b0, is_long ? wfm_pkg::LenExt16 : head_i.frame_length[6:0]};
      end else if (is_long && step_q == 3'd2) begin
        byte_d = head_i.frame_length[15:8];
      end else if (is_long && step_q == 3'd3) begin
        byte_d = head_i.frame_length[7:0];
      end else begin
        byte_d = wfm_pkg::mask_byte(head_i.mask_key, mask_idx[1:0]);
        last_d = (step_q == last_step) && (head_i.frame_length == 16'd0);
      end
    end
  end

  always_comb begin
    pop_o  = load && (!is_hdr || step_q == last_step);
    step_d = step_q;
    if (pop_o)     step_d = 3'd0;
    else if (load) step_d = step_q + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load)              out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q  <= byte_d;
      out_last_q  <= last_d;
      out_error_q <= head_i.error && !is_hdr;
    end
  end

endmodule

>>> hw/rtl/websocket_frame_masker_core.sv
// ----------------------------------------------------------------------------
// websocket_frame_masker_core
// client-to-server websocket frame encoder with payload masking
// ----------------------------------------------------------------------------
// usage:
//   in_i  carries start items (func 0: opcode, frame_length, mask_key) and
//         payload items (func 1: data_byte); a transfer is valid && ready
//   out_o carries the frame one byte per transfer, last on the final byte,
//         error on a payload byte that arrived with no open frame
// a start item gives 6 bytes (length below 126) or 8 bytes (extended
// 16-bit length); each payload item gives one masked byte
// the first byte of an item passes through the command queue and then the
// output register before it can transfer on out_o
// throughput: one payload byte per cycle while out_o.ready stays high; a
// header holds the back end while its 6 or 8 bytes go one by one through the
// single output register, and the front keeps taking items until the command queue (Depth) fills
// reset: no frame open, queue and output register empty
// when the receiver stalls the output register holds, the back end stops,
// and the queue fills before in_i.ready drops
// ----------------------------------------------------------------------------
module websocket_frame_masker_core #(
  parameter int unsigned Depth = wfm_pkg::QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wfm_in_if.sink    in_i,
  wfm_out_if.source out_o
);

  // front to queue
  logic              push;
  logic              q_full;
  wfm_pkg::wfm_cmd_t push_cmd;

  // queue to back
  logic              pop;
  logic              q_empty;
  wfm_pkg::wfm_cmd_t head_cmd;

  // classify items, keep frame state, mask payload bytes
  wfm_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // decouples item intake from header expansion
  wfm_queue #(
    .Depth (Depth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .empty_o (q_empty)
  );

  // header byte sequencer and output register
  wfm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_cmd),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
